// File: hw/rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Types and constants shared by the reaction step block.
// ----------------------------------------------------------------------------
`default_nettype none
package gsp_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned BIN_W     = 6;

  localparam logic [23:0] LN2_Q24  = 24'd11629080;
  localparam logic [63:0] PROP_CAP = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] TIME_SAT = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_A   = 3'd0,
    REG_RATE_B   = 3'd1,
    REG_BIND     = 3'd2,
    REG_DECAY    = 3'd3,
    REG_START_A  = 3'd4,
    REG_START_B  = 3'd5,
    REG_START_C  = 3'd6,
    REG_END_TIME = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/gsp_mul.sv
// ----------------------------------------------------------------------------
// gsp_mul
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module gsp_mul (
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] prod
);
  always_ff @(posedge clk) begin
    prod <= {32'd0, a} * {32'd0, b};
  end
endmodule
`default_nettype wire

// File: hw/rtl/gsp_div.sv
// ----------------------------------------------------------------------------
// gsp_div
// Restoring 64/64 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module gsp_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [63:0]       dividend,
  input  wire logic [63:0]       divisor,
  output logic      [63:0]       quotient,
  output gsp_pkg::div_stat_t     stat
);
  import gsp_pkg::*;

  logic [64:0] rem;
  logic [63:0] dvs;
  logic [5:0]  cnt;
  logic [64:0] shifted;
  logic        qbit;

  always_comb begin
    shifted = {rem[63:0], quotient[63]};
    qbit    = (shifted >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !start && stat.busy && (cnt == 6'd63);
      if (start) begin
        quotient  <= dividend;
        dvs       <= divisor;
        rem       <= '0;
        cnt       <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem      <= qbit ? (shifted - {1'b0, dvs}) : shifted;
        quotient <= {quotient[62:0], qbit};
        cnt      <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/gillespie_reaction_step.sv
// ----------------------------------------------------------------------------
// gillespie_reaction_step
// One direct-method stochastic simulation step of a four-reaction network.
// ----------------------------------------------------------------------------
// When a reaction fires, a transaction goes from acceptance to result thus:
// a shared 32x32 multiplier computes the propensities, 32 squaring passes of
// the logarithm and the reaction pick, and a shared one bit per cycle divider
// then computes the time step and the histogram bin. A finished transaction
// returns straight from the check state, and one with no possible reaction
// skips the logarithm and the time step. The input stalls while a step is in
// progress or a result waits to be taken. No reset sweep is needed.
`default_nettype none
module gillespie_reaction_step #(
  parameter int unsigned BIN_COUNT = 50
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           restart,
  input  wire logic [31:0]                    uniform_a,
  input  wire logic [31:0]                    uniform_b,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          event_res,
  output logic [31:0]                         sim_time_out,
  output logic [15:0]                         count_a,
  output logic [15:0]                         count_b,
  output logic [15:0]                         count_c,
  output logic [gsp_pkg::BIN_W-1:0]           bin_index,
  output logic                                bin_valid,
  output logic                                finished
);
  import gsp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_G2B, S_G2C, S_G2D, S_TOT, S_LOG, S_LN1, S_LN2, S_LN3,
    S_UB2, S_UB3, S_DIV, S_BIN1, S_BIN2, S_BIN3, S_OUT
  } state_t;

  state_t      state;
  logic [31:0] rate_make_a, rate_make_b, rate_bind, rate_decay;
  logic [15:0] start_a, start_b, start_c, end_time;
  logic [15:0] pop_a, pop_b, pop_c;
  logic [31:0] sim_time;
  logic [31:0] ub, xr;
  logic [5:0]  lexp;
  logic [31:0] frac;
  logic [4:0]  lcnt;
  logic [47:0] g2t;
  logic [63:0] plo;
  logic [62:0] total, c0, c1, c2;
  logic [63:0] lnq;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        div_start;
  logic [63:0] div_n, div_d, quo;
  div_stat_t   dstat;

  logic [31:0] ua_eff, ua_norm;
  logic [5:0]  ua_exp;
  logic [32:0] xsq;
  logic [31:0] x_new;
  logic [37:0] nl;
  logic [63:0] g2full, g2sat;
  logic [62:0] tot_c, c1_c, c2_c;
  logic [95:0] pub;
  logic [1:0]  ev_c;
  logic [31:0] dt;
  logic [32:0] nt;

  gsp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  gsp_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_n), .divisor(div_d),
    .quotient(quo), .stat(dstat)
  );

  assign cfg_ready    = 1'b1;
  assign in_stall     = (state != S_IDLE) || out_valid;
  assign sim_time_out = sim_time;
  assign count_a      = pop_a;
  assign count_b      = pop_b;
  assign count_c      = pop_c;

  always_comb begin
    ua_eff = (uniform_a == 32'd0) ? 32'd1 : uniform_a;
    ua_exp = 6'd0;
    for (int i = 0; i < 32; i++) begin
      if (ua_eff[i]) ua_exp = 6'(i);
    end
    ua_norm = ua_eff << (6'd31 - ua_exp);
    xsq     = prod[63:31];
    x_new   = xsq[32] ? xsq[32:1] : xsq[31:0];
    nl      = {lexp, 32'd0} - {6'd0, frac};
    g2full  = {prod[31:0], 32'd0} + plo;
    g2sat   = (g2full > PROP_CAP) ? PROP_CAP : g2full;
    c1_c    = {31'd0, rate_make_a} + {31'd0, rate_make_b};
    c2_c    = c1_c + g2sat[62:0];
    tot_c   = c2 + {15'd0, prod[47:0]};
    pub     = {prod, 32'd0} + {32'd0, plo};
    if (pub <= {1'b0, c0, 32'd0})      ev_c = 2'd0;
    else if (pub <= {1'b0, c1, 32'd0}) ev_c = 2'd1;
    else if (pub <= {1'b0, c2, 32'd0}) ev_c = 2'd2;
    else                               ev_c = 2'd3;
    dt = (quo[63:32] != 32'd0) ? TIME_SAT : quo[31:0];
    nt = {1'b0, sim_time} + {1'b0, dt};
  end

  always_comb begin
    mul_a = xr;
    mul_b = xr;
    unique case (state)
      S_CHECK: begin mul_a = rate_bind;          mul_b = {16'd0, pop_a}; end
      S_G2B:   begin mul_a = prod[31:0];         mul_b = {16'd0, pop_b}; end
      S_G2C:   begin mul_a = {16'd0, g2t[47:32]}; mul_b = {16'd0, pop_b}; end
      S_G2D:   begin mul_a = rate_decay;         mul_b = {16'd0, pop_c}; end
      S_LOG:   begin mul_a = x_new;              mul_b = x_new; end
      S_LN1:   begin mul_a = nl[31:0];           mul_b = {8'd0, LN2_Q24}; end
      S_LN2:   begin mul_a = {26'd0, nl[37:32]};  mul_b = {8'd0, LN2_Q24}; end
      S_LN3:   begin mul_a = ub;                 mul_b = total[31:0]; end
      S_UB2:   begin mul_a = ub;                 mul_b = {1'b0, total[62:32]}; end
      S_BIN1:  begin mul_a = sim_time;           mul_b = 32'(BIN_COUNT); end
      default: begin mul_a = xr;                 mul_b = xr; end
    endcase
    div_start = (state == S_UB3) || (state == S_BIN2);
    div_n     = (state == S_UB3) ? lnq : prod;
    div_d     = (state == S_UB3) ? {1'b0, total} : {32'd0, end_time, 16'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      rate_make_a <= 32'd16777216;
      rate_make_b <= 32'd16777216;
      rate_bind   <= 32'd16777;
      rate_decay  <= 32'd167772;
      start_a     <= 16'd120;
      start_b     <= 16'd80;
      start_c     <= 16'd1;
      end_time    <= 16'd200;
      pop_a       <= '0;
      pop_b       <= '0;
      pop_c       <= '0;
      sim_time    <= TIME_SAT;
      event_res   <= '0;
      bin_index   <= '0;
      bin_valid   <= 1'b0;
      finished    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_RATE_A:   rate_make_a <= cfg_data;
          REG_RATE_B:   rate_make_b <= cfg_data;
          REG_BIND:     rate_bind   <= cfg_data;
          REG_DECAY:    rate_decay  <= cfg_data;
          REG_START_A:  start_a     <= cfg_data[15:0];
          REG_START_B:  start_b     <= cfg_data[15:0];
          REG_START_C:  start_c     <= cfg_data[15:0];
          REG_END_TIME: end_time    <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            if (restart) begin
              pop_a    <= start_a;
              pop_b    <= start_b;
              pop_c    <= start_c;
              sim_time <= '0;
            end
            ub        <= uniform_b;
            xr        <= ua_norm;
            lexp      <= 6'd32 - ua_exp;
            event_res <= '0;
            bin_index <= '0;
            bin_valid <= 1'b0;
            finished  <= 1'b0;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (sim_time >= {end_time, 16'd0}) begin
            finished  <= 1'b1;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            state <= S_G2B;
          end
        end
        S_G2B: begin
          g2t   <= prod[47:0];
          state <= S_G2C;
        end
        S_G2C: begin
          plo   <= prod;
          state <= S_G2D;
        end
        S_G2D: begin
          g2t   <= g2t;
          c2    <= c2_c;
          state <= S_TOT;
        end
        S_TOT: begin
          total <= tot_c;
          c0    <= {31'd0, rate_make_a};
          c1    <= c1_c;
          frac  <= '0;
          lcnt  <= '0;
          if (tot_c == 63'd0) begin
            sim_time <= TIME_SAT;
            state    <= S_BIN1;
          end else begin
            state <= S_LOG;
          end
        end
        S_LOG: begin
          xr    <= x_new;
          frac  <= {frac[30:0], xsq[32]};
          lcnt  <= lcnt + 5'd1;
          if (lcnt == 5'd31) state <= S_LN1;
        end
        S_LN1: state <= S_LN2;
        S_LN2: begin
          plo   <= prod;
          state <= S_LN3;
        end
        S_LN3: begin
          lnq   <= {18'd0, g2full[61:16]};
          state <= S_UB2;
        end
        S_UB2: begin
          plo   <= prod;
          state <= S_UB3;
        end
        S_UB3: begin
          event_res <= ev_c;
          unique case (ev_c)
            2'd0: pop_a <= (pop_a == 16'hFFFF) ? pop_a : pop_a + 16'd1;
            2'd1: pop_b <= (pop_b == 16'hFFFF) ? pop_b : pop_b + 16'd1;
            2'd2: begin
              pop_a <= (pop_a == 16'd0) ? pop_a : pop_a - 16'd1;
              pop_b <= (pop_b == 16'd0) ? pop_b : pop_b - 16'd1;
              pop_c <= (pop_c == 16'hFFFF) ? pop_c : pop_c + 16'd1;
            end
            default: pop_c <= (pop_c == 16'd0) ? pop_c : pop_c - 16'd1;
          endcase
          state <= S_DIV;
        end
        S_DIV: begin
          if (dstat.done) begin
            sim_time <= nt[32] ? TIME_SAT : nt[31:0];
            state    <= S_BIN1;
          end
        end
        S_BIN1: state <= S_BIN2;
        S_BIN2: state <= S_BIN3;
        S_BIN3: begin
          if (dstat.done) begin
            if (quo < 64'(BIN_COUNT)) begin
              bin_index <= quo[BIN_W-1:0];
              bin_valid <= 1'b1;
            end
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fin_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> event_res == 2'd0 && !bin_valid)
    else $error("finished result carries step data");

  a_bin_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && bin_valid |-> bin_index < BIN_COUNT)
    else $error("histogram bin out of range");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !dstat.busy)
    else $error("divider restarted while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted during a step");

endmodule
`default_nettype wire

// File: tb/gsp_step_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gsp_step_checker
// Watches the configuration, input and result channels of the reaction step
// block, predicts each result from its own copy of the rates, populations and
// time, and compares every result transaction field by field in order.
// ----------------------------------------------------------------------------
module gsp_step_checker #(
  parameter int unsigned BINS = 50
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [gsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          restart,
  input  logic [31:0]                   uniform_a,
  input  logic [31:0]                   uniform_b,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [1:0]                    event_res,
  input  logic [31:0]                   sim_time_out,
  input  logic [15:0]                   count_a,
  input  logic [15:0]                   count_b,
  input  logic [15:0]                   count_c,
  input  logic [gsp_pkg::BIN_W-1:0]     bin_index,
  input  logic                          bin_valid,
  input  logic                          finished,
  output int                            errors,
  output int                            pending
);
  import gsp_pkg::*;

  typedef struct packed {
    logic [1:0]       ev;
    logic [31:0]      t;
    logic [15:0]      a;
    logic [15:0]      b;
    logic [15:0]      c;
    logic [BIN_W-1:0] bin;
    logic             bv;
    logic             fin;
  } step_t;

  step_t step_q[$];

  logic [31:0] k_a, k_b, k_bind, k_decay;
  logic [15:0] init_a, init_b, init_c, t_end;
  logic [15:0] na, nb, nc;
  logic [31:0] now;

  function automatic logic [63:0] neg_log2(logic [31:0] u);
    int p;
    logic [63:0] x;
    logic [63:0] fr;
    p = 31;
    fr = '0;
    while (p > 0 && !u[p]) p--;
    x = 64'(u) << (31 - p);
    for (int i = 0; i < 32; i++) begin
      x = (x * x) >> 31;
      fr = fr << 1;
      if (x >= 64'h1_0000_0000) begin
        x = x >> 1;
        fr[0] = 1'b1;
      end
    end
    return (64'(32 - p) << 32) - fr;
  endfunction

  function automatic logic hits(logic [63:0] hi, logic [63:0] lo, logic [63:0] c);
    return hi < c || (hi == c && lo == 0);
  endfunction

  function automatic logic [15:0] up(logic [15:0] v);
    return v == 16'hFFFF ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] down(logic [15:0] v);
    return v == 0 ? v : v - 16'd1;
  endfunction

  task automatic take_step(input logic rs, input logic [31:0] ua, input logic [31:0] ub);
    step_t r;
    logic [31:0] end_q;
    logic [63:0] g0, g1, g2, g3, total, lnq, dt, nt, plo, hi, lo, q;
    r = '0;
    end_q = {t_end, 16'd0};
    if (rs) begin
      na = init_a; nb = init_b; nc = init_c; now = 0;
    end
    if (now >= end_q) begin
      r.fin = 1'b1;
    end else begin
      g0 = k_a;
      g1 = k_b;
      g2 = 64'(k_bind) * na;
      g3 = 64'(k_decay) * nc;
      if (nb != 0 && g2 > PROP_CAP / nb) g2 = PROP_CAP;
      else g2 = g2 * nb;
      total = g0 + g1 + g2 + g3;
      if (total == 0) begin
        now = TIME_SAT;
      end else begin
        lnq = (neg_log2(ua == 0 ? 32'd1 : ua) * LN2_Q24) >> 16;
        dt = lnq / total;
        plo = 64'(ub) * total[31:0];
        hi = 64'(ub) * (total >> 32) + (plo >> 32);
        lo = {32'd0, plo[31:0]};
        if (hits(hi, lo, g0)) r.ev = 2'd0;
        else if (hits(hi, lo, g0 + g1)) r.ev = 2'd1;
        else if (hits(hi, lo, g0 + g1 + g2)) r.ev = 2'd2;
        else r.ev = 2'd3;
        case (r.ev)
          2'd0: na = up(na);
          2'd1: nb = up(nb);
          2'd2: begin
            na = down(na); nb = down(nb); nc = up(nc);
          end
          default: nc = down(nc);
        endcase
        if (dt > TIME_SAT) dt = TIME_SAT;
        nt = 64'(now) + dt;
        now = nt > TIME_SAT ? TIME_SAT : nt[31:0];
      end
      q = (64'(now) * BINS) / end_q;
      if (q < BINS) begin
        r.bin = q[BIN_W-1:0];
        r.bv = 1'b1;
      end
    end
    r.t = now; r.a = na; r.b = nb; r.c = nc;
    step_q.push_back(r);
  endtask

  assign pending = step_q.size();

  always @(posedge clk) begin
    step_t e, got;
    if (rst) begin
      k_a <= 32'd16777216; k_b <= 32'd16777216; k_bind <= 32'd16777; k_decay <= 32'd167772;
      init_a <= 16'd120; init_b <= 16'd80; init_c <= 16'd1; t_end <= 16'd200;
      na = 0; nb = 0; nc = 0; now = TIME_SAT;
      step_q.delete();
      errors <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{event_res, sim_time_out, count_a, count_b, count_c, bin_index, bin_valid,
                finished};
        if (step_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result transaction: %p", got);
        end else begin
          e = step_q.pop_front();
          if (got !== e) begin
            errors <= errors + 1;
            if (errors < 10) $display("result mismatch: expected %p actual %p", e, got);
          end
        end
      end
      if (in_valid && !in_stall) take_step(restart, uniform_a, uniform_b);
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_RATE_A:   k_a <= cfg_data;
          REG_RATE_B:   k_b <= cfg_data;
          REG_BIND:     k_bind <= cfg_data;
          REG_DECAY:    k_decay <= cfg_data;
          REG_START_A:  init_a <= cfg_data[15:0];
          REG_START_B:  init_b <= cfg_data[15:0];
          REG_START_C:  init_c <= cfg_data[15:0];
          REG_END_TIME: t_end <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/tb_gillespie_reaction_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gillespie_reaction_step
// Drives directed and random step transactions through several rate, start
// population and end time settings, with random gaps and output stalls; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_gillespie_reaction_step;
  import gsp_pkg::*;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, restart;
  logic [31:0] uniform_a, uniform_b;
  logic out_valid, out_stall;
  logic [1:0] event_res;
  logic [31:0] sim_time_out;
  logic [15:0] count_a, count_b, count_c;
  logic [BIN_W-1:0] bin_index;
  logic bin_valid, finished;
  int errors, pending;
  logic calm;

  gillespie_reaction_step dut (.*);

  gsp_step_checker chk (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("gillespie_reaction_step regression: fail");
    $finish;
  end

  always @(negedge clk) out_stall <= !calm && $urandom_range(99) < 31;

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1; cfg_index = idx; cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  task automatic settle();
    while (pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic step(input logic rs, input logic [31:0] ua, input logic [31:0] ub);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 31) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid = 1; restart = rs; uniform_a = ua; uniform_b = ub;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  function automatic logic [31:0] pick_ua();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(1, 255);
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(7))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h00FF_FFFF);
      3: return $urandom_range(0, 32'h0000_FFFF);
      default: return $urandom_range(32'h0010_0000, 32'h0400_0000);
    endcase
  endfunction

  task automatic set_all(input logic [31:0] ra, input logic [31:0] rb, input logic [31:0] rc,
                         input logic [31:0] rd, input logic [15:0] sa, input logic [15:0] sb,
                         input logic [15:0] sc, input logic [15:0] te);
    settle();
    write_reg(REG_RATE_A, ra);
    write_reg(REG_RATE_B, rb);
    write_reg(REG_BIND, rc);
    write_reg(REG_DECAY, rd);
    write_reg(REG_START_A, {16'($urandom), sa});
    write_reg(REG_START_B, {16'($urandom), sb});
    write_reg(REG_START_C, {16'($urandom), sc});
    write_reg(REG_END_TIME, {16'($urandom), te});
  endtask

  initial begin
    int n;
    rst = 1; calm = 0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; restart = 0; uniform_a = '0; uniform_b = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // stepping before any restart, then extremes of the uniforms
    step(0, $urandom, $urandom);
    step(1, 0, 0);
    step(0, 1, 32'hFFFF_FFFF);
    step(0, 32'hFFFF_FFFF, 32'h8000_0000);
    step(0, 32'h8000_0000, 32'h0000_0001);
    step(1, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    step(0, 32'h5555_5555, 32'hAAAA_AAAA);
    step(0, 32'hAAAA_AAAA, 32'h5555_5555);
    // all propensities zero
    set_all(0, 0, 0, 0, 0, 0, 0, 16'd5);
    step(1, $urandom, $urandom);
    step(0, $urandom, 0);
    step(0, $urandom, $urandom);
    // saturating propensities and populations
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    step(1, 0, 0);
    step(0, 1, 32'h4000_0000);
    step(0, $urandom, 32'hFFFF_FFFF);
    step(0, $urandom, 32'hC000_0000);
    // bind and decay only, empty start populations
    set_all(0, 0, 32'h0100_0000, 32'h0100_0000, 0, 0, 0, 16'd1);
    step(1, 1, $urandom);
    step(0, $urandom, $urandom);
    step(0, 1, 32'hFFFF_FFFF);

    for (int ph = 0; ph < 13; ph++) begin
      case (ph)
        0: set_all(32'd16777216, 32'd16777216, 32'd16777, 32'd167772, 120, 80, 1, 200);
        1: set_all(0, 0, 0, 0, 16'($urandom), 16'($urandom), 16'($urandom), 16'd1);
        2: set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_all(32'h0100_0000, 32'h0100_0000, 32'h0000_1000, 32'h0010_0000,
                   16'hFFFF, 0, 16'hFFFF, 16'd1);
        default: set_all(pick_rate(), pick_rate(), pick_rate(), pick_rate(),
                         16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                         16'($urandom_range(0, 50)), 16'($urandom_range(1, 40)));
      endcase
      n = (ph == 1) ? 40 : 158;
      for (int i = 0; i < n; i++) begin
        calm = (ph == 5 || ph == 6);
        step(i == 0 || $urandom_range(99) < 4, pick_ua(),
             $urandom_range(9) == 0 ? ($urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF) : $urandom);
      end
      calm = 0;
    end

    @(negedge clk);
    in_valid = 0;
    settle();
    if (errors == 0) begin
      $display("gillespie_reaction_step regression: pass");
    end else begin
      $display("gillespie_reaction_step regression: fail");
    end
    $finish;
  end
endmodule

// File: sim.f
hw/rtl/gsp_pkg.sv
hw/rtl/gsp_mul.sv
hw/rtl/gsp_div.sv
hw/rtl/gillespie_reaction_step.sv
tb/gsp_step_checker.sv
tb/tb_gillespie_reaction_step.sv
